[design/ktmp_pkg.sv]
// ----------------------------------------------------------------------------
// ktmp_pkg: shared types and constants for the k-transaction profit block
// Holds the fixed field widths, the configuration reset value and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package ktmp_pkg;

  // fixed field widths
  localparam int CFG_W    = 5;
  localparam int PROFIT_W = 20;

  // transaction count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

[design/ktmp_ram.sv]
// ----------------------------------------------------------------------------
// ktmp_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ktmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ktmp_alu.sv]
// ----------------------------------------------------------------------------
// ktmp_alu: shared cell update unit
// Updates one transaction cell: best holding balance, then best sold profit.
// ----------------------------------------------------------------------------
module ktmp_alu #(
  parameter int W = 23
) (
  input  logic signed [W-1:0] price,
  input  logic signed [W-1:0] prev_sold,
  input  logic signed [W-1:0] hold_in,
  input  logic signed [W-1:0] sold_in,
  output logic signed [W-1:0] hold_out,
  output logic signed [W-1:0] sold_out
);

  logic signed [W-1:0] buy;
  logic signed [W-1:0] sell;

  // buy against the previous cell's profit, keep the better balance
  always_comb begin
    buy      = prev_sold - price;
    hold_out = (buy > hold_in) ? buy : hold_in;
    sell     = hold_out + price;
    sold_out = (sell > sold_in) ? sell : sold_in;
  end

endmodule

[design/k_transaction_max_profit.sv]
// ----------------------------------------------------------------------------
// k_transaction_max_profit: best stock profit with at most k transactions
// Takes one price per input transaction and returns the best profit so far
// with at most the configured number of buy-sell transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_price and in_last. Each accepted
//   price sweeps the cells 0..MAX_TRANSACTIONS-1 through one shared update
//   unit, one cell per cycle, with cell state kept in two small rams.
//   Result channel out_valid/out_ready carries out_best_profit and
//   out_last_res; every input yields exactly one result.
//   A result goes through the RUN sweep and the DONE handover before out_valid;
//   no new price is taken until both have ended, a pace set by the
//   cell sweep through the single update unit and ram port.
//   in_ready is high only while the sequencer is idle. A finished result sits
//   in the output register, so the next price may be accepted while it waits;
//   if the receiver still stalls when the next sweep ends, the sequencer holds.
//   cfg_we/cfg_wdata set the transaction count (clamped to MAX_TRANSACTIONS);
//   write it only while idle. A price with in_last set clears all cells after
//   its result is formed.
//   Reset (rst_n low, synchronous) sets the count to 2, marks every cell empty
//   and drops out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module k_transaction_max_profit #(
  parameter int MAX_TRANSACTIONS = 16,
  parameter int PRICE_BITS       = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PRICE_BITS-1:0]         in_price,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ktmp_pkg::PROFIT_W-1:0] out_best_profit,
  output logic                          out_last_res,
  input  logic                          cfg_we,
  input  logic [ktmp_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int W     = PRICE_BITS + 7;
  localparam int AW    = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_TRANSACTIONS + 1);
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(MAX_TRANSACTIONS - 1);
  localparam logic signed [W-1:0] HOLD_FLOOR = {2'b11, {(W-2){1'b0}}};

  ktmp_pkg::state_t state_r, state_nxt;

  logic [ktmp_pkg::CFG_W-1:0]    trans_r, trans_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic [PRICE_BITS-1:0]         price_r, price_nxt;
  logic                          last_r, last_nxt;
  logic [MAX_TRANSACTIONS-1:0]   valid_r, valid_nxt;
  logic signed [W-1:0]           prev_sold_r, prev_sold_nxt;
  logic signed [W-1:0]           best_r, best_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ktmp_pkg::PROFIT_W-1:0] out_profit_r, out_profit_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          in_accept;
  logic [AW-1:0]                 cell_idx;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [W-1:0]                  rd_hold;
  logic [W-1:0]                  rd_sold;
  logic signed [W-1:0]           cur_hold;
  logic signed [W-1:0]           cur_sold;
  logic signed [W-1:0]           price_ext;
  logic signed [W-1:0]           new_hold;
  logic signed [W-1:0]           new_sold;
  logic [W-1:0]                  best_u;

  assign in_ready        = (state_r == ktmp_pkg::ST_IDLE);
  assign in_accept       = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_best_profit = out_profit_r;
  assign out_last_res    = out_last_r;

  assign cell_idx  = cnt_r[AW-1:0];
  assign wr_en     = (state_r == ktmp_pkg::ST_RUN);
  assign price_ext = signed'({{(W-PRICE_BITS){1'b0}}, price_r});
  assign best_u    = unsigned'(best_r);

  // read address runs one cell ahead of the update
  always_comb begin
    if (state_r == ktmp_pkg::ST_RUN) begin
      rd_addr = AW'(cnt_r + 1'b1);
    end else begin
      rd_addr = '0;
    end
  end

  // cell state storage
  ktmp_ram #(.WIDTH(W), .DEPTH(MAX_TRANSACTIONS)) u_hold_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cell_idx),
    .wdata (unsigned'(new_hold)),
    .raddr (rd_addr),
    .rdata (rd_hold)
  );

  ktmp_ram #(.WIDTH(W), .DEPTH(MAX_TRANSACTIONS)) u_sold_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cell_idx),
    .wdata (unsigned'(new_sold)),
    .raddr (rd_addr),
    .rdata (rd_sold)
  );

  // empty cells read as their reset values
  always_comb begin
    cur_hold = valid_r[cell_idx] ? signed'(rd_hold) : HOLD_FLOOR;
    cur_sold = valid_r[cell_idx] ? signed'(rd_sold) : '0;
  end

  // shared update unit
  ktmp_alu #(.W(W)) u_alu (
    .price     (price_ext),
    .prev_sold (prev_sold_r),
    .hold_in   (cur_hold),
    .sold_in   (cur_sold),
    .hold_out  (new_hold),
    .sold_out  (new_sold)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    trans_nxt      = trans_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    price_nxt      = price_r;
    last_nxt       = last_r;
    valid_nxt      = valid_r;
    prev_sold_nxt  = prev_sold_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_profit_nxt = out_profit_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      trans_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ktmp_pkg::ST_IDLE: begin
        if (in_accept) begin
          price_nxt     = in_price;
          last_nxt      = in_last;
          cnt_nxt       = '0;
          prev_sold_nxt = '0;
          best_nxt      = '0;
          if (int'(trans_r) > MAX_TRANSACTIONS) begin
            k_nxt = CNT_W'(MAX_TRANSACTIONS);
          end else begin
            k_nxt = CNT_W'(trans_r);
          end
          state_nxt = ktmp_pkg::ST_RUN;
        end
      end
      ktmp_pkg::ST_RUN: begin
        valid_nxt[cell_idx] = 1'b1;
        prev_sold_nxt       = new_sold;
        // capture the configured cell's profit
        if ((CNT_W + 1)'(cnt_r) + 1'b1 == (CNT_W + 1)'(k_r)) begin
          best_nxt = new_sold;
        end
        if (cnt_r == LAST_CELL) begin
          state_nxt = ktmp_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ktmp_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_profit_nxt = ktmp_pkg::PROFIT_W'(best_u);
          out_last_nxt   = last_r;
          if (last_r) begin
            valid_nxt = '0;
          end
          state_nxt = ktmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ktmp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ktmp_pkg::ST_IDLE;
      trans_r     <= ktmp_pkg::CFG_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      trans_r     <= trans_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    price_r      <= price_nxt;
    last_r       <= last_nxt;
    prev_sold_r  <= prev_sold_nxt;
    best_r       <= best_nxt;
    out_profit_r <= out_profit_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

[design/ktmp_checker.sv]
// ----------------------------------------------------------------------------
// ktmp_checker: port-level checks for the k-transaction profit block
// Watches the top level's handshakes over time; attached by bind.
// ----------------------------------------------------------------------------
module ktmp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ktmp_pkg::PROFIT_W-1:0] out_best_profit,
  input logic                          out_last_res
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_profit)
      && $stable(out_last_res))
    else $error("ktmp: stalled result changed");

  // an accepted price keeps the block busy; in_ready must not return early
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("ktmp: ready returned too early after a transaction");

  // a new result only appears at the end of a sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("ktmp: result appeared while idle");

  // no result in the cycle after accepting a price while no result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("ktmp: result appeared right after a transaction");

endmodule

bind k_transaction_max_profit ktmp_checker u_ktmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_best_profit (out_best_profit),
  .out_last_res    (out_last_res)
);
